// File: rtl/homography_point_project_assert.svh
// Assertion macros shared by the homography point projector checks
`ifndef HOMOGRAPHY_POINT_PROJECT_ASSERT_SVH
`define HOMOGRAPHY_POINT_PROJECT_ASSERT_SVH

// same-cycle implication, held off while in reset
`define HPP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("homography point projector check failed");

// next-cycle implication, held off while in reset
`define HPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("homography point projector check failed");

`endif

// File: rtl/hpp_pkg.sv
// Types and constants for the homography point projector
package hpp_pkg;

    localparam int DATA_W        = 32;
    localparam int COORD_W       = 12;
    localparam int NUM_REGS      = 8;
    localparam int IDX_W         = 3;
    localparam int PROD_W        = DATA_W + COORD_W + 1;
    localparam int SUM_W         = PROD_W + 1;
    localparam int Q_W           = 34;
    localparam int LATENCY       = Q_W + 5;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [IDX_W-1:0] {
        REG_M00 = 3'd0,
        REG_M01 = 3'd1,
        REG_M02 = 3'd2,
        REG_M10 = 3'd3,
        REG_M11 = 3'd4,
        REG_M12 = 3'd5,
        REG_M20 = 3'd6,
        REG_M21 = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] m00;
        logic signed [DATA_W-1:0] m01;
        logic signed [DATA_W-1:0] m02;
        logic signed [DATA_W-1:0] m10;
        logic signed [DATA_W-1:0] m11;
        logic signed [DATA_W-1:0] m12;
        logic signed [DATA_W-1:0] m20;
        logic signed [DATA_W-1:0] m21;
    } t_matrix;

    typedef struct packed {
        logic                     valid;
        logic signed [SUM_W-1:0]  nx;
        logic signed [SUM_W-1:0]  ny;
        logic signed [SUM_W-1:0]  w;
        logic signed [DATA_W-1:0] off_x;
        logic signed [DATA_W-1:0] off_y;
    } t_sums;

    typedef struct packed {
        logic                     valid;
        logic                     neg;
        logic                     ovf;
        logic [Q_W-1:0]           quot;
        logic signed [DATA_W-1:0] off;
    } t_div_res;

endpackage

// File: rtl/hpp_cfg.sv
// Matrix coefficient registers with write port
module hpp_cfg #(
    parameter int FRAC_BITS = hpp_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [hpp_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [hpp_pkg::DATA_W-1:0]  i_cfg_data,
    output hpp_pkg::t_matrix            o_matrix
);
    import hpp_pkg::*;

    localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_BITS;

    t_matrix r_matrix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // identity
            r_matrix <= '{m00: ONE_Q, m01: '0, m02: '0,
                          m10: '0, m11: ONE_Q, m12: '0,
                          m20: '0, m21: '0};
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_M00: r_matrix.m00 <= i_cfg_data;
                REG_M01: r_matrix.m01 <= i_cfg_data;
                REG_M02: r_matrix.m02 <= i_cfg_data;
                REG_M10: r_matrix.m10 <= i_cfg_data;
                REG_M11: r_matrix.m11 <= i_cfg_data;
                REG_M12: r_matrix.m12 <= i_cfg_data;
                REG_M20: r_matrix.m20 <= i_cfg_data;
                REG_M21: r_matrix.m21 <= i_cfg_data;
                default: r_matrix <= r_matrix;
            endcase
        end
    end

    assign o_matrix = r_matrix;

endmodule

// File: rtl/hpp_mac.sv
// Two-stage multiply-accumulate forming X, Y and W for each point
module hpp_mac #(
    parameter int FRAC_BITS = hpp_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [hpp_pkg::COORD_W-1:0]       i_pixel_x,
    input  logic [hpp_pkg::COORD_W-1:0]       i_pixel_y,
    input  logic signed [hpp_pkg::DATA_W-1:0] i_offset_x,
    input  logic signed [hpp_pkg::DATA_W-1:0] i_offset_y,
    input  hpp_pkg::t_matrix                  i_matrix,
    output hpp_pkg::t_sums                    o_sums
);
    import hpp_pkg::*;

    localparam logic signed [SUM_W-1:0] W_ONE = SUM_W'(1) << FRAC_BITS;

    // stage A: products
    logic                     r_valid_a;
    logic signed [PROD_W-1:0] r_px0, r_py0, r_px1, r_py1, r_px2, r_py2;
    logic signed [DATA_W-1:0] r_offx_a, r_offy_a;
    logic signed [PROD_W-1:0] n_px0, n_py0, n_px1, n_py1, n_px2, n_py2;
    logic signed [COORD_W:0]  xs, ys;

    // stage B: sums
    logic                     r_valid_b;
    logic signed [SUM_W-1:0]  r_nx, r_ny, r_w;
    logic signed [DATA_W-1:0] r_offx_b, r_offy_b;
    logic signed [SUM_W-1:0]  n_nx, n_ny, n_w;

    always_comb begin
        xs    = $signed({1'b0, i_pixel_x});
        ys    = $signed({1'b0, i_pixel_y});
        n_px0 = $signed(i_matrix.m00) * xs;
        n_py0 = $signed(i_matrix.m01) * ys;
        n_px1 = $signed(i_matrix.m10) * xs;
        n_py1 = $signed(i_matrix.m11) * ys;
        n_px2 = $signed(i_matrix.m20) * xs;
        n_py2 = $signed(i_matrix.m21) * ys;
    end

    always_comb begin
        n_nx = SUM_W'(r_px0) + SUM_W'(r_py0) + SUM_W'($signed(i_matrix.m02));
        n_ny = SUM_W'(r_px1) + SUM_W'(r_py1) + SUM_W'($signed(i_matrix.m12));
        n_w  = SUM_W'(r_px2) + SUM_W'(r_py2) + W_ONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px0    <= n_px0;
        r_py0    <= n_py0;
        r_px1    <= n_px1;
        r_py1    <= n_py1;
        r_px2    <= n_px2;
        r_py2    <= n_py2;
        r_offx_a <= i_offset_x;
        r_offy_a <= i_offset_y;
        r_nx     <= n_nx;
        r_ny     <= n_ny;
        r_w      <= n_w;
        r_offx_b <= r_offx_a;
        r_offy_b <= r_offy_a;
    end

    assign o_sums = '{valid: r_valid_b, nx: r_nx, ny: r_ny, w: r_w,
                      off_x: r_offx_b, off_y: r_offy_b};

endmodule

// File: rtl/hpp_div.sv
// Pipelined restoring divider: one quotient bit per stage, Q_W stages
module hpp_div #(
    parameter int FRAC_BITS = hpp_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [hpp_pkg::SUM_W-1:0]  i_num,
    input  logic signed [hpp_pkg::SUM_W-1:0]  i_den,
    input  logic signed [hpp_pkg::DATA_W-1:0] i_off,
    output hpp_pkg::t_div_res                 o_res
);
    import hpp_pkg::*;

    // magnitude stage
    logic                     r1_valid, r1_neg;
    logic [SUM_W-1:0]         r1_nm, r1_dm;
    logic signed [DATA_W-1:0] r1_off;

    // division stages; index 0 holds the initial partial remainder
    logic                     r_valid [Q_W+1];
    logic                     r_neg   [Q_W+1];
    logic                     r_ovf   [Q_W+1];
    logic [SUM_W-1:0]         r_rem   [Q_W+1];
    logic [SUM_W-1:0]         r_dm    [Q_W+1];
    logic [Q_W-1:0]           r_nq    [Q_W+1];
    logic signed [DATA_W-1:0] r_off   [Q_W+1];

    logic [SUM_W-1:0]         n_rem   [Q_W+1];
    logic [Q_W-1:0]           n_nq    [Q_W+1];
    logic [SUM_W-1:0]         rem0;

    // top bits of nm * 2^F; at or above the divisor means the quotient needs > Q_W bits
    assign rem0 = r1_nm >> (Q_W - FRAC_BITS);

    always_comb begin
        logic [SUM_W:0] t;
        logic [SUM_W:0] d;
        n_rem[0] = rem0;
        n_nq[0]  = r1_nm[Q_W-1:0] << FRAC_BITS;
        for (int k = 0; k < Q_W; k++) begin
            t = {r_rem[k], r_nq[k][Q_W-1]};
            d = {1'b0, r_dm[k]};
            if (t >= d) begin
                n_rem[k+1] = SUM_W'(t - d);
                n_nq[k+1]  = {r_nq[k][Q_W-2:0], 1'b1};
            end else begin
                n_rem[k+1] = t[SUM_W-1:0];
                n_nq[k+1]  = {r_nq[k][Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            for (int k = 0; k <= Q_W; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else begin
            r1_valid   <= i_valid;
            r_valid[0] <= r1_valid;
            for (int k = 0; k < Q_W; k++) begin
                r_valid[k+1] <= r_valid[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_nm  <= i_num[SUM_W-1] ? $unsigned(-i_num) : $unsigned(i_num);
        r1_dm  <= i_den[SUM_W-1] ? $unsigned(-i_den) : $unsigned(i_den);
        r1_neg <= i_num[SUM_W-1] ^ i_den[SUM_W-1];
        r1_off <= i_off;

        r_rem[0] <= n_rem[0];
        r_nq[0]  <= n_nq[0];
        r_dm[0]  <= r1_dm;
        r_ovf[0] <= (rem0 >= r1_dm);
        r_neg[0] <= r1_neg;
        r_off[0] <= r1_off;
        for (int k = 0; k < Q_W; k++) begin
            r_rem[k+1] <= n_rem[k+1];
            r_nq[k+1]  <= n_nq[k+1];
            r_dm[k+1]  <= r_dm[k];
            r_ovf[k+1] <= r_ovf[k];
            r_neg[k+1] <= r_neg[k];
            r_off[k+1] <= r_off[k];
        end
    end

    assign o_res = '{valid: r_valid[Q_W], neg: r_neg[Q_W], ovf: r_ovf[Q_W],
                     quot: r_nq[Q_W], off: r_off[Q_W]};

endmodule

// File: rtl/hpp_sat.sv
// Offset add, saturation and registered result outputs
module hpp_sat (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  hpp_pkg::t_div_res                  i_res_x,
    input  hpp_pkg::t_div_res                  i_res_y,
    output logic                               o_strobe,
    output logic signed [hpp_pkg::DATA_W-1:0]  o_world_x,
    output logic signed [hpp_pkg::DATA_W-1:0]  o_world_y,
    output logic                               o_fault
);
    import hpp_pkg::*;

    localparam int ACC_W = Q_W + 3;
    localparam logic [Q_W:0] Q_LIM = {1'b1, {Q_W{1'b0}}};

    typedef struct packed {
        logic                     clamped;
        logic signed [DATA_W-1:0] value;
    } t_sat;

    function automatic t_sat add_clamp(t_div_res res);
        logic [Q_W:0]             q;
        logic signed [ACC_W-1:0]  ext;
        logic signed [ACC_W-1:0]  qs;
        logic signed [ACC_W-1:0]  s;
        t_sat                     r;
        // quotient too large (or zero divisor) forces a clamp in the sign's direction
        q   = res.ovf ? Q_LIM : {1'b0, res.quot};
        ext = ACC_W'(res.off);
        qs  = $signed({2'b00, q});
        s   = res.neg ? ext - qs : ext + qs;
        if (!s[ACC_W-1] && (|s[ACC_W-2:DATA_W-1])) begin
            r.clamped = 1'b1;
            r.value   = S32_MAX;
        end else if (s[ACC_W-1] && !(&s[ACC_W-2:DATA_W-1])) begin
            r.clamped = 1'b1;
            r.value   = S32_MIN;
        end else begin
            r.clamped = 1'b0;
            r.value   = s[DATA_W-1:0];
        end
        return r;
    endfunction

    t_sat sx, sy;
    logic r_strobe;
    logic r_fault;
    logic signed [DATA_W-1:0] r_world_x, r_world_y;

    assign sx = add_clamp(i_res_x);
    assign sy = add_clamp(i_res_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_res_x.valid & i_res_y.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_world_x <= sx.value;
        r_world_y <= sy.value;
        r_fault   <= sx.clamped | sy.clamped;
    end

    assign o_strobe  = r_strobe;
    assign o_world_x = r_world_x;
    assign o_world_y = r_world_y;
    assign o_fault   = r_fault;

endmodule

// File: rtl/homography_point_project.sv
// A request is accepted when start is high and busy is low; o_strobe marks its result.
// Throughput: one point per cycle; the 34-stage divider pair (one quotient bit per stage)
// sets the depth, two multiply/add stages and three more register stages make up the rest.
// Reset (synchronous, active low) clears the pipeline valid bits and loads the identity
// matrix; busy stays high until the first cycle after reset is released, then stays low.
module homography_point_project #(
    parameter int FRAC_BITS = hpp_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [hpp_pkg::COORD_W-1:0]       i_pixel_x,
    input  logic [hpp_pkg::COORD_W-1:0]       i_pixel_y,
    input  logic signed [hpp_pkg::DATA_W-1:0] i_offset_x,
    input  logic signed [hpp_pkg::DATA_W-1:0] i_offset_y,
    input  logic                              i_cfg_we,
    input  logic [hpp_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [hpp_pkg::DATA_W-1:0]        i_cfg_data,
    output logic                              o_strobe,
    output logic signed [hpp_pkg::DATA_W-1:0] o_world_x,
    output logic signed [hpp_pkg::DATA_W-1:0] o_world_y,
    output logic                              o_fault
);
    import hpp_pkg::*;

    logic     r_busy;
    logic     req;
    t_matrix  matrix;
    t_sums    sums;
    t_div_res res_x, res_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy = r_busy;
    assign req  = start & ~r_busy;

    hpp_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_matrix    (matrix)
    );

    hpp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (req),
        .i_pixel_x  (i_pixel_x),
        .i_pixel_y  (i_pixel_y),
        .i_offset_x (i_offset_x),
        .i_offset_y (i_offset_y),
        .i_matrix   (matrix),
        .o_sums     (sums)
    );

    hpp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sums.valid),
        .i_num   (sums.nx),
        .i_den   (sums.w),
        .i_off   (sums.off_x),
        .o_res   (res_x)
    );

    hpp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sums.valid),
        .i_num   (sums.ny),
        .i_den   (sums.w),
        .i_off   (sums.off_y),
        .o_res   (res_y)
    );

    hpp_sat u_sat (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_res_x   (res_x),
        .i_res_y   (res_y),
        .o_strobe  (o_strobe),
        .o_world_x (o_world_x),
        .o_world_y (o_world_y),
        .o_fault   (o_fault)
    );

endmodule

// File: rtl/hpp_checker.sv
// Port-level checks for the homography point projector, bound to the top level
`include "homography_point_project_assert.svh"

module hpp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_strobe,
    input logic signed [hpp_pkg::DATA_W-1:0] o_world_x,
    input logic signed [hpp_pkg::DATA_W-1:0] o_world_y,
    input logic                              o_fault
);
    import hpp_pkg::*;

    localparam int LAT_CNT = LATENCY + 1;
    localparam int CNT_W   = $clog2(LAT_CNT + 1);

    // cycles since reset release, saturating once the pipeline history is all post-reset
    logic [CNT_W-1:0] r_cnt;
    logic             settled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_cnt != CNT_W'(LAT_CNT)) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign settled = (r_cnt == CNT_W'(LAT_CNT));

    // once settled, every request gives exactly one result, and no result comes without a request
    `HPP_ASSERT_IMPLY(a_latency, i_clk, i_rst_n, settled,
        o_strobe == $past(start && !busy, LATENCY))

    // no result can come out before a request has had time to cross the pipeline
    `HPP_ASSERT_IMPLY(a_no_early_result, i_clk, i_rst_n, o_strobe, settled)

    // a fault always shows as at least one coordinate at a 32-bit limit
    `HPP_ASSERT_IMPLY(a_fault_clamped, i_clk, i_rst_n, o_strobe && o_fault,
        (o_world_x == S32_MAX) || (o_world_x == S32_MIN) ||
        (o_world_y == S32_MAX) || (o_world_y == S32_MIN))

endmodule

bind homography_point_project hpp_checker u_hpp_checker (.*);

// File: tb/tb_homography_point_project.sv
`timescale 1ns / 1ps
// Self-checking testbench for the homography point projector: directed corners, then random sweeps
module tb_homography_point_project;
    import hpp_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic signed [DATA_W-1:0] world_x;
        logic signed [DATA_W-1:0] world_y;
        logic                     fault;
    } t_world_point;

    class point_scoreboard;
        logic signed [DATA_W-1:0] coeff [NUM_REGS];
        t_world_point             expected_q [$];
        int                       mismatches;

        function new();
            foreach (coeff[i]) coeff[i] = '0;
            coeff[REG_M00] = 1 << FRAC;
            coeff[REG_M11] = 1 << FRAC;
            mismatches     = 0;
        endfunction

        function void load_coeff(t_reg_idx idx, logic [DATA_W-1:0] data);
            coeff[idx] = data;
        endfunction

        // quotient to FRAC fraction bits, truncated toward zero, then offset and clamp
        function longint quotient_plus(longint num, longint den, longint off, inout bit sat);
            bit [63:0] num_mag;
            bit [63:0] den_mag;
            bit [63:0] quot;
            longint    total;
            num_mag = (num < 0) ? -num : num;
            den_mag = (den < 0) ? -den : den;
            if (num_mag / den_mag >= (64'd1 << (Q_W - FRAC)))
                quot = 64'd1 << Q_W;
            else
                quot = (num_mag << FRAC) / den_mag;
            total = ((num < 0) != (den < 0)) ? off - longint'(quot) : off + longint'(quot);
            if (total > longint'(S32_MAX)) begin
                sat = 1'b1;
                return longint'(S32_MAX);
            end
            if (total < longint'(S32_MIN)) begin
                sat = 1'b1;
                return longint'(S32_MIN);
            end
            return total;
        endfunction

        function void note_request(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                   logic signed [DATA_W-1:0] ox,
                                   logic signed [DATA_W-1:0] oy);
            longint       x;
            longint       y;
            longint       nx;
            longint       ny;
            longint       w;
            longint       rx;
            longint       ry;
            bit           sat;
            t_world_point pt;
            x  = px;
            y  = py;
            nx = longint'(coeff[REG_M00]) * x + longint'(coeff[REG_M01]) * y
                 + longint'(coeff[REG_M02]);
            ny = longint'(coeff[REG_M10]) * x + longint'(coeff[REG_M11]) * y
                 + longint'(coeff[REG_M12]);
            w  = longint'(coeff[REG_M20]) * x + longint'(coeff[REG_M21]) * y
                 + (longint'(1) << FRAC);
            sat = 1'b0;
            if (w == 0) begin
                // point at infinity: sign of the numerator picks the rail, offsets dropped
                rx  = (nx < 0) ? longint'(S32_MIN) : longint'(S32_MAX);
                ry  = (ny < 0) ? longint'(S32_MIN) : longint'(S32_MAX);
                sat = 1'b1;
            end else begin
                rx = quotient_plus(nx, w, ox, sat);
                ry = quotient_plus(ny, w, oy, sat);
            end
            pt.world_x = rx[DATA_W-1:0];
            pt.world_y = ry[DATA_W-1:0];
            pt.fault   = sat;
            expected_q.push_back(pt);
        endfunction

        function void check_result(logic signed [DATA_W-1:0] wx, logic signed [DATA_W-1:0] wy,
                                   logic flt);
            t_world_point pt;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result x=%0d y=%0d fault=%0b", $time, wx, wy, flt);
                return;
            end
            pt = expected_q.pop_front();
            if (wx !== pt.world_x || wy !== pt.world_y || flt !== pt.fault) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: mismatch exp x=%0d y=%0d fault=%0b, got x=%0d y=%0d fault=%0b",
                             $time, pt.world_x, pt.world_y, pt.fault, wx, wy, flt);
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [COORD_W-1:0]       i_pixel_x;
    logic [COORD_W-1:0]       i_pixel_y;
    logic signed [DATA_W-1:0] i_offset_x;
    logic signed [DATA_W-1:0] i_offset_y;
    logic                     i_cfg_we;
    logic [IDX_W-1:0]         i_cfg_index;
    logic [DATA_W-1:0]        i_cfg_data;
    logic                     o_strobe;
    logic signed [DATA_W-1:0] o_world_x;
    logic signed [DATA_W-1:0] o_world_y;
    logic                     o_fault;

    logic [DATA_W-1:0] next_mat [NUM_REGS];
    int unsigned       idle_odds;
    int unsigned       stall_cycles = 0;
    point_scoreboard   sb;

    homography_point_project #(.FRAC_BITS(FRAC)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_pixel_x   (i_pixel_x),
        .i_pixel_y   (i_pixel_y),
        .i_offset_x  (i_offset_x),
        .i_offset_y  (i_offset_y),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_world_x   (o_world_x),
        .o_world_y   (o_world_y),
        .o_fault     (o_fault)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.load_coeff(t_reg_idx'(i_cfg_index), i_cfg_data);
            if (start && !busy)
                sb.note_request(i_pixel_x, i_pixel_y, i_offset_x, i_offset_y);
            if (o_strobe)
                sb.check_result(o_world_x, o_world_y, o_fault);
            if (i_cfg_we || (start && !busy) || o_strobe) begin
                stall_cycles <= 0;
            end else if (stall_cycles == STALL_LIMIT) begin
                $display("tb_homography_point_project failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    function automatic int signed_spread(int unsigned s);
        return int'($urandom_range(0, 2 * s)) - int'(s);
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_offset();
        case ($urandom_range(0, 5))
            0:       return S32_MAX;
            1:       return S32_MIN;
            2, 3:    return signed_spread(1 << 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic void fill_matrix(logic [DATA_W-1:0] value);
        foreach (next_mat[r]) next_mat[r] = value;
    endfunction

    task automatic feed_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                              logic [DATA_W-1:0] ox, logic [DATA_W-1:0] oy);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_pixel_x  <= px;
        i_pixel_y  <= py;
        i_offset_x <= ox;
        i_offset_y <= oy;
        do @(posedge i_clk); while (busy);
    endtask

    // step past the current edge first so the request taken at that edge is already queued
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_matrix();
        for (int r = 0; r < NUM_REGS; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= t_reg_idx'(r);
            i_cfg_data  <= next_mat[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned        line_sum;
        bit                 wild;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        sb          = new();
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_pixel_x   <= '0;
        i_pixel_y   <= '0;
        i_offset_x  <= '0;
        i_offset_y  <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_M00;
        i_cfg_data  <= '0;
        idle_odds   = 4;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity out of reset: corners and offset rails
        feed_point(0, 0, 0, 0);
        feed_point(4095, 4095, 0, 0);
        feed_point(4095, 0, S32_MAX, S32_MIN);
        feed_point(0, 4095, S32_MIN, S32_MAX);
        feed_point(4095, 4095, S32_MAX, S32_MIN);
        feed_point(1, 2, -1, -1);
        drain_results();

        // w vanishes on column 2048, x numerator negative there
        fill_matrix('0);
        next_mat[REG_M00] = -(1 << FRAC);
        next_mat[REG_M11] = 1 << FRAC;
        next_mat[REG_M20] = -32;
        load_matrix();
        feed_point(2048, 0, 5, 5);
        feed_point(2048, 300, 0, 0);
        feed_point(0, 4095, 7, -7);
        feed_point(2047, 9, 0, 0);
        feed_point(2049, 4095, 0, 0);
        drain_results();

        fill_matrix(S32_MAX);
        load_matrix();
        feed_point(0, 0, 0, 0);
        feed_point(4095, 4095, S32_MIN, S32_MAX);
        feed_point(1, 0, S32_MAX, 0);
        drain_results();

        fill_matrix(S32_MIN);
        load_matrix();
        feed_point(0, 0, 0, 0);
        feed_point(4095, 4095, S32_MAX, S32_MIN);
        feed_point(0, 1, -1, 1);
        drain_results();

        fill_matrix('0);
        load_matrix();
        feed_point(4095, 4095, S32_MAX, S32_MIN);
        feed_point(123, 456, 0, -1);
        drain_results();

        for (int phase = 0; phase < 16; phase++) begin
            wild = ($urandom_range(0, 3) == 0);
            foreach (next_mat[r]) begin
                if (wild) begin
                    case ($urandom_range(0, 3))
                        0:       next_mat[r] = S32_MAX;
                        1:       next_mat[r] = S32_MIN;
                        default: next_mat[r] = $urandom;
                    endcase
                end else begin
                    case (t_reg_idx'(r))
                        REG_M00, REG_M11: next_mat[r] = (1 << FRAC) + signed_spread(1 << 17);
                        REG_M01, REG_M10: next_mat[r] = signed_spread(1 << 16);
                        REG_M02, REG_M12: next_mat[r] = signed_spread(1 << 26);
                        default:          next_mat[r] = signed_spread(64);
                    endcase
                end
            end
            // equal perspective terms put a line x + y = line_sum where w is zero
            line_sum = 0;
            if (!wild && $urandom_range(0, 2) == 0) begin
                line_sum          = 1024 << $urandom_range(0, 2);
                next_mat[REG_M20] = -((1 << FRAC) / line_sum);
                next_mat[REG_M21] = next_mat[REG_M20];
            end
            if (phase >= 13 || phase % 3 == 0)
                idle_odds = 0;
            else
                idle_odds = $urandom_range(2, 8);
            load_matrix();
            repeat (50) begin
                if (line_sum != 0 && $urandom_range(0, 3) == 0) begin
                    px = COORD_W'($urandom_range(line_sum > 4095 ? 4095 : line_sum,
                                                 line_sum > 4095 ? line_sum - 4095 : 0));
                    py = COORD_W'(line_sum - px);
                end else begin
                    px = pick_coord();
                    py = pick_coord();
                end
                feed_point(px, py, pick_offset(), pick_offset());
            end
            drain_results();
        end

        repeat (2 * LATENCY) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("tb_homography_point_project passed");
        else
            $display("tb_homography_point_project failed");
        $finish;
    end

endmodule
